>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/mpe_pkg.sv
// Types and constants of the MPE section to Ethernet converter.
package mpe_pkg;

  // Section position counter and its limits.
  localparam int IDX_W             = 13;
  typedef logic [IDX_W-1:0] idx_t;
  localparam int MAX_SECTION_BYTES = 4096;
  localparam int HDR_BYTES         = 12;
  localparam int MIN_SECTION_BYTES = 16;
  localparam int ETH_HDR_BYTES     = 14;
  localparam int CRC_BYTES         = 4;

  localparam idx_t IDX_MAX      = {IDX_W{1'b1}};
  localparam idx_t IDX_HDR_END  = idx_t'(HDR_BYTES - 1);
  localparam idx_t IDX_HDR      = idx_t'(HDR_BYTES);
  localparam idx_t IDX_MAXSEC   = idx_t'(MAX_SECTION_BYTES);
  localparam idx_t IDX_PAY_OUT  = idx_t'(MIN_SECTION_BYTES);

  // Payload length field.
  localparam int PL_W = 12;
  typedef logic [PL_W-1:0] pl_t;

  // Header check constants.
  localparam logic [7:0] SEL_MASK    = 8'hfd;
  localparam logic [7:0] SEL_VALUE   = 8'hc1;
  localparam logic [7:0] LLC_BIT     = 8'h02;
  localparam logic [7:0] ETH_TYPE_HI = 8'h08;
  localparam logic [7:0] ETH_TYPE_LO = 8'h00;

  // Closing status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD      = 3'd2,
    ST_LLC      = 3'd3,
    ST_FRAG     = 3'd4,
    ST_OVERSIZE = 3'd5
  } status_t;

  // Destination address class.
  typedef enum logic [1:0] {
    CL_UNICAST   = 2'd0,
    CL_MULTICAST = 2'd1,
    CL_BROADCAST = 2'd2
  } class_t;

endpackage

>>> rtl/mpe_in_if.sv
// Input channel: one section byte per word with a last-byte mark.
interface mpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] section_byte;
  logic       last_byte;

  modport source (output valid, output section_byte, output last_byte, input ready);
  modport sink (input valid, input section_byte, input last_byte, output ready);
endinterface

>>> rtl/mpe_out_if.sv
// Output channel: Ethernet frame bytes and closing status words.
interface mpe_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        frame_byte;
  logic              frame_byte_valid;
  logic              frame_end;
  mpe_pkg::status_t  status;
  mpe_pkg::class_t   frame_class;
  mpe_pkg::pl_t      payload_length;
  logic [31:0]       good_frames;
  logic [31:0]       error_frames;

  modport source (
    output valid, output frame_byte, output frame_byte_valid, output frame_end,
    output status, output frame_class, output payload_length,
    output good_frames, output error_frames, input ready
  );
  modport sink (
    input valid, input frame_byte, input frame_byte_valid, input frame_end,
    input status, input frame_class, input payload_length,
    input good_frames, input error_frames, output ready
  );
endinterface

>>> rtl/mpe_section_to_ethernet_top.sv
// Top level of the MPE section to Ethernet frame converter.
//
// The sec channel takes one section byte per word, header first, with
// last_byte set on the final byte. The frm channel returns frame bytes
// (frame_byte_valid high) and, once per section, a closing status word
// (frame_end high) with the class, payload length and running counters.
// Each accepted byte is decoded in the accept cycle into a pending slot;
// the slot feeds a single output register that drives frm. One word
// leaves per cycle, and payload bytes are accepted one per cycle, while
// frm is ready. Header byte 11 of a good header queues the 14-byte
// Ethernet header, which holds input until its last byte leaves; the
// final byte of a forwarded section carries both a payload byte and the
// closing word, which holds input until its payload byte leaves.
// When frm stalls, the output register holds and the pending slot fills,
// after which sec ready drops. Reset clears the position counter, header
// verdict, counters and all pending and output valid flags; no clearing
// pass is needed. A section with a bad header still closes with a status
// word; frame bytes already delivered for it are to be discarded.
`include "assert_macros.svh"

module mpe_section_to_ethernet_top (
  input  logic          clk,
  input  logic          rst,
  mpe_in_if.sink        sec,
  mpe_out_if.source     frm
);

  localparam logic [3:0] HDR_LAST = 4'(mpe_pkg::ETH_HDR_BYTES - 1);

  // Section state.
  mpe_pkg::idx_t    byte_index;
  logic [7:0]       header_store [mpe_pkg::HDR_BYTES];
  logic [7:0]       crc_delay [mpe_pkg::CRC_BYTES];
  mpe_pkg::status_t header_verdict;
  logic [31:0]      packet_count;
  logic [31:0]      byte_count;
  logic [31:0]      error_count;
  logic [31:0]      dropped_count;

  // Pending slot: queued Ethernet header, payload byte and closing word.
  logic             hdr_v;
  logic [3:0]       hdr_idx;
  logic             pay_v;
  logic [7:0]       pay_byte;
  logic             end_v;
  mpe_pkg::status_t end_status;
  mpe_pkg::class_t  end_class;
  mpe_pkg::pl_t     end_pl;
  logic [31:0]      end_good;
  logic [31:0]      end_err;

  // Output register.
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_byte_valid;
  logic             out_end;
  mpe_pkg::status_t out_status;
  mpe_pkg::class_t  out_class;
  mpe_pkg::pl_t     out_pl;
  logic [31:0]      out_good;
  logic [31:0]      out_err;

  // Decode signals.
  logic             in_fire;
  logic             is_hdr;
  logic             is_over;
  logic             is_pay;
  mpe_pkg::status_t hdr_check;
  mpe_pkg::status_t verdict_upd;
  mpe_pkg::status_t st;
  mpe_pkg::class_t  cls;
  logic             emit_hdr;
  logic             emit_pay;
  logic [13:0]      len;
  logic [13:0]      pl_full;
  mpe_pkg::pl_t     pl_sat;
  logic             all_ff;
  logic             cnt_good;
  logic             cnt_llc;
  logic             cnt_err;
  logic [31:0]      packet_count_next;
  logic [31:0]      error_count_next;
  logic             out_free;
  logic             pend_any;
  logic             pend_last;
  logic [7:0]       hdr_byte;

  assign in_fire = sec.valid && sec.ready;

  // Position classes of the incoming byte.
  assign is_hdr  = byte_index < mpe_pkg::IDX_HDR;
  assign is_over = byte_index >= mpe_pkg::IDX_MAXSEC;
  assign is_pay  = !is_hdr && !is_over;

  // Header check on bytes 5 and 7.
  always_comb begin
    if ((header_store[5] & mpe_pkg::SEL_MASK) != mpe_pkg::SEL_VALUE) begin
      hdr_check = mpe_pkg::ST_BAD;
    end else if ((header_store[5] & mpe_pkg::LLC_BIT) != 8'h00) begin
      hdr_check = mpe_pkg::ST_LLC;
    end else if (header_store[7] != 8'h00) begin
      hdr_check = mpe_pkg::ST_FRAG;
    end else begin
      hdr_check = mpe_pkg::ST_OK;
    end
  end

  // Verdict after this byte, before the section closes.
  always_comb begin
    if (byte_index == mpe_pkg::IDX_HDR_END) begin
      verdict_upd = hdr_check;
    end else if (is_over && header_verdict == mpe_pkg::ST_OK) begin
      verdict_upd = mpe_pkg::ST_OVERSIZE;
    end else begin
      verdict_upd = header_verdict;
    end
  end

  assign emit_hdr = (byte_index == mpe_pkg::IDX_HDR_END) && (hdr_check == mpe_pkg::ST_OK)
                    && !sec.last_byte;
  assign emit_pay = is_pay && (byte_index >= mpe_pkg::IDX_PAY_OUT)
                    && (header_verdict == mpe_pkg::ST_OK);

  // Closing status and payload length.
  assign len     = {1'b0, byte_index} + 14'd1;
  assign pl_full = len - 14'(mpe_pkg::MIN_SECTION_BYTES);
  assign pl_sat  = (pl_full > 14'({mpe_pkg::PL_W{1'b1}})) ? {mpe_pkg::PL_W{1'b1}}
                                                           : pl_full[mpe_pkg::PL_W-1:0];
  assign st      = (len < 14'(mpe_pkg::MIN_SECTION_BYTES)) ? mpe_pkg::ST_SHORT : verdict_upd;

  // Destination class from the stored MAC bytes.
  assign all_ff = (header_store[11] == 8'hff) && (header_store[10] == 8'hff) &&
                  (header_store[9] == 8'hff) && (header_store[8] == 8'hff) &&
                  (header_store[4] == 8'hff) && (header_store[3] == 8'hff);
  always_comb begin
    if (!header_store[11][0]) begin
      cls = mpe_pkg::CL_UNICAST;
    end else if (all_ff) begin
      cls = mpe_pkg::CL_BROADCAST;
    end else begin
      cls = mpe_pkg::CL_MULTICAST;
    end
  end

  // Counter updates on a closing byte.
  assign cnt_good = sec.last_byte && (st == mpe_pkg::ST_OK);
  assign cnt_llc  = sec.last_byte && (st == mpe_pkg::ST_LLC);
  assign cnt_err  = sec.last_byte && (st != mpe_pkg::ST_OK) && (st != mpe_pkg::ST_LLC);
  assign packet_count_next = packet_count + {31'd0, cnt_good};
  assign error_count_next  = error_count + {31'd0, cnt_err};

  // Section state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index     <= '0;
      header_verdict <= mpe_pkg::ST_OK;
      packet_count   <= '0;
      byte_count     <= '0;
      error_count    <= '0;
      dropped_count  <= '0;
    end else if (in_fire) begin
      packet_count <= packet_count_next;
      error_count  <= error_count_next;
      if (cnt_good) begin
        byte_count <= byte_count + 32'(pl_full) + 32'(mpe_pkg::ETH_HDR_BYTES);
      end
      if (cnt_llc) begin
        dropped_count <= dropped_count + 32'd1;
      end
      if (sec.last_byte) begin
        byte_index     <= '0;
        header_verdict <= mpe_pkg::ST_OK;
      end else begin
        header_verdict <= verdict_upd;
        if (byte_index != mpe_pkg::IDX_MAX) begin
          byte_index <= byte_index + mpe_pkg::idx_t'(1);
        end
      end
    end
  end

  // Header store and CRC delay line; contents are read only after being written.
  always_ff @(posedge clk) begin
    if (in_fire && is_hdr) begin
      header_store[byte_index[3:0]] <= sec.section_byte;
    end
    if (in_fire && is_pay) begin
      crc_delay[0] <= crc_delay[1];
      crc_delay[1] <= crc_delay[2];
      crc_delay[2] <= crc_delay[3];
      crc_delay[3] <= sec.section_byte;
    end
  end

  // Ethernet header byte at the current position.
  always_comb begin
    case (hdr_idx)
      4'd0:    hdr_byte = header_store[11];
      4'd1:    hdr_byte = header_store[10];
      4'd2:    hdr_byte = header_store[9];
      4'd3:    hdr_byte = header_store[8];
      4'd4:    hdr_byte = header_store[4];
      4'd5:    hdr_byte = header_store[3];
      4'd12:   hdr_byte = mpe_pkg::ETH_TYPE_HI;
      4'd13:   hdr_byte = mpe_pkg::ETH_TYPE_LO;
      default: hdr_byte = 8'h00;
    endcase
  end

  // Input is taken when the pending slot empties this cycle.
  assign out_free  = !out_valid || frm.ready;
  assign pend_any  = hdr_v || pay_v || end_v;
  assign pend_last = (hdr_v && hdr_idx == HDR_LAST && !pay_v && !end_v) ||
                     (!hdr_v && (pay_v ^ end_v));
  assign sec.ready = !pend_any || (pend_last && out_free);

  // Pending slot: drained one word per cycle while out_free, reloaded on accept.
  // An accept needs an empty slot or its last word leaving this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_v <= 1'b0;
      pay_v <= 1'b0;
      end_v <= 1'b0;
    end else if (in_fire) begin
      hdr_v      <= emit_hdr;
      hdr_idx    <= 4'd0;
      pay_v      <= emit_pay;
      pay_byte   <= crc_delay[0];
      end_v      <= sec.last_byte;
      end_status <= st;
      end_class  <= (st == mpe_pkg::ST_OK) ? cls : mpe_pkg::CL_UNICAST;
      end_pl     <= (st == mpe_pkg::ST_OK) ? pl_sat : '0;
      end_good   <= packet_count_next;
      end_err    <= error_count_next;
    end else if (out_free && pend_any) begin
      if (hdr_v) begin
        if (hdr_idx == HDR_LAST) begin
          hdr_v <= 1'b0;
        end
        hdr_idx <= hdr_idx + 4'd1;
      end else if (pay_v) begin
        pay_v <= 1'b0;
      end else begin
        end_v <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pend_any;
      if (hdr_v || pay_v) begin
        out_byte       <= hdr_v ? hdr_byte : pay_byte;
        out_byte_valid <= 1'b1;
        out_end        <= 1'b0;
        out_status     <= mpe_pkg::ST_OK;
        out_class      <= mpe_pkg::CL_UNICAST;
        out_pl         <= '0;
        out_good       <= '0;
        out_err        <= '0;
      end else begin
        out_byte       <= 8'h00;
        out_byte_valid <= 1'b0;
        out_end        <= 1'b1;
        out_status     <= end_status;
        out_class      <= end_class;
        out_pl         <= end_pl;
        out_good       <= end_good;
        out_err        <= end_err;
      end
    end
  end

  assign frm.valid            = out_valid;
  assign frm.frame_byte       = out_byte;
  assign frm.frame_byte_valid = out_byte_valid;
  assign frm.frame_end        = out_end;
  assign frm.status           = out_status;
  assign frm.frame_class      = out_class;
  assign frm.payload_length   = out_pl;
  assign frm.good_frames      = out_good;
  assign frm.error_frames     = out_err;

  // The Ethernet header burst keeps input closed until its final byte.
  `ASSERT_IMP(a_hdr_blocks_input, clk, rst, hdr_v && hdr_idx != HDR_LAST, !sec.ready)
  // A closing byte restarts the section position.
  `ASSERT_NXT(a_last_restarts, clk, rst, in_fire && sec.last_byte, byte_index == '0)
  // Rejected sections report unicast class and zero length.
  `ASSERT_IMP(a_reject_fields, clk, rst,
    out_valid && out_end && out_status != mpe_pkg::ST_OK,
    out_class == mpe_pkg::CL_UNICAST && out_pl == '0)

endmodule

>>> verif/tb_mpe_section_to_ethernet_top.sv
// Testbench of the MPE section to Ethernet converter: sections checked word by word.
`timescale 1ns / 1ps

module tb_mpe_section_to_ethernet_top;

  // Header byte positions that the header check reads.
  localparam int SEL_POS  = 5;
  localparam int FRAG_POS = 7;

  // One word of the frame channel.
  typedef struct {
    logic [7:0]        frame_byte;
    logic              frame_byte_valid;
    logic              frame_end;
    mpe_pkg::status_t  status;
    mpe_pkg::class_t   frame_class;
    mpe_pkg::pl_t      payload_length;
    logic [31:0]       good_frames;
    logic [31:0]       error_frames;
  } frame_word_t;

  // One word of the section channel, with an optional hand-written closing status.
  typedef struct {
    logic [7:0]        section_byte;
    logic              last_byte;
    bit                status_given;
    mpe_pkg::status_t  given_status;
  } section_word_t;

  // One directed section, with the closing status it must produce.
  typedef struct {
    int                len;
    logic [7:0]        sel_byte;
    logic [7:0]        frag_byte;
    logic [47:0]       dest_mac;
    logic [7:0]        fill;
    mpe_pkg::status_t  status;
  } directed_section_t;

  logic clk;
  logic rst;
  int   failures = 0;

  mpe_in_if  sec();
  mpe_out_if frm();

  mpe_section_to_ethernet_top DUT (
    .clk(clk),
    .rst(rst),
    .sec(sec),
    .frm(frm)
  );

  // Directed sections: a one-byte section, a section that ends on the last
  // header byte, and the shortest good section with a broadcast address.
  directed_section_t directed_rows [3] = '{
    '{1,  8'h00, 8'h00, 48'h0, 8'h00, mpe_pkg::ST_SHORT},
    '{12, mpe_pkg::SEL_VALUE, 8'h00, 48'h021a2b3c4d5e, 8'h5a, mpe_pkg::ST_SHORT},
    '{16, mpe_pkg::SEL_VALUE, 8'h00, 48'hffffffffffff, 8'hff, mpe_pkg::ST_OK}
  };

  // Converter state as the testbench sees it.
  mpe_pkg::idx_t    sec_pos = '0;
  logic [7:0]       hdr_bytes [mpe_pkg::HDR_BYTES];
  logic [7:0]       crc_line [mpe_pkg::CRC_BYTES];
  mpe_pkg::status_t hdr_verdict = mpe_pkg::ST_OK;
  logic [31:0]      frames_good = '0;
  logic [31:0]      frames_failed = '0;
  frame_word_t      pending_words [$];
  section_word_t    section_words [$];
  int               accepted_words = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset, held high from time zero and released at a falling edge.
  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Overall time limit.
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic mpe_pkg::status_t judge_header();
    if ((hdr_bytes[SEL_POS] & mpe_pkg::SEL_MASK) != mpe_pkg::SEL_VALUE) return mpe_pkg::ST_BAD;
    if ((hdr_bytes[SEL_POS] & mpe_pkg::LLC_BIT) != 8'h00) return mpe_pkg::ST_LLC;
    if (hdr_bytes[FRAG_POS] != 8'h00) return mpe_pkg::ST_FRAG;
    return mpe_pkg::ST_OK;
  endfunction

  // Destination address, first transmitted byte in the top bits.
  function automatic logic [47:0] dest_address();
    return {hdr_bytes[11], hdr_bytes[10], hdr_bytes[9], hdr_bytes[8],
            hdr_bytes[4], hdr_bytes[3]};
  endfunction

  // Random destination of a random class; bit 40 is the group bit.
  function automatic logic [47:0] random_dest();
    logic [47:0] a;
    a = {16'($urandom), 32'($urandom)};
    case ($urandom_range(0, 2))
      0: a[40] = 1'b0;
      1: a[40] = 1'b1;
      default: a = '1;
    endcase
    return a;
  endfunction

  task automatic push_frame_byte(input logic [7:0] b);
    pending_words.push_back('{b, 1'b1, 1'b0, mpe_pkg::ST_OK, mpe_pkg::CL_UNICAST,
                              '0, '0, '0});
  endtask

  // Works out the frame words that one accepted section byte causes.
  task automatic convert_byte(input logic [7:0] b, input logic last,
                              input bit status_given, input mpe_pkg::status_t given_status);
    mpe_pkg::idx_t    pos;
    logic [47:0]      dest;
    int               len;
    mpe_pkg::status_t st;
    mpe_pkg::class_t  cls;
    mpe_pkg::pl_t     plen;
    pos = sec_pos;
    if (pos < mpe_pkg::IDX_HDR) begin
      hdr_bytes[pos[3:0]] = b;
      // The last header byte decides the verdict and releases the Ethernet header.
      if (pos == mpe_pkg::IDX_HDR_END) begin
        hdr_verdict = judge_header();
        if (hdr_verdict == mpe_pkg::ST_OK && !last) begin
          dest = dest_address();
          for (int i = 5; i >= 0; i--) push_frame_byte(dest[i*8 +: 8]);
          repeat (6) push_frame_byte(8'h00);
          push_frame_byte(mpe_pkg::ETH_TYPE_HI);
          push_frame_byte(mpe_pkg::ETH_TYPE_LO);
        end
      end
    end else if (pos >= mpe_pkg::IDX_MAXSEC) begin
      if (hdr_verdict == mpe_pkg::ST_OK) hdr_verdict = mpe_pkg::ST_OVERSIZE;
    end else begin
      // Payload runs through a four-byte delay so that the CRC never leaves.
      if (pos >= mpe_pkg::IDX_PAY_OUT && hdr_verdict == mpe_pkg::ST_OK) begin
        push_frame_byte(crc_line[0]);
      end
      for (int i = 0; i < mpe_pkg::CRC_BYTES - 1; i++) crc_line[i] = crc_line[i + 1];
      crc_line[mpe_pkg::CRC_BYTES - 1] = b;
    end

    // The final byte closes the section with a status word.
    if (last) begin
      len  = int'(pos) + 1;
      st   = (len < mpe_pkg::MIN_SECTION_BYTES) ? mpe_pkg::ST_SHORT : hdr_verdict;
      cls  = mpe_pkg::CL_UNICAST;
      plen = '0;
      if (st == mpe_pkg::ST_OK) begin
        dest = dest_address();
        cls  = !dest[40] ? mpe_pkg::CL_UNICAST :
               ((&dest) ? mpe_pkg::CL_BROADCAST : mpe_pkg::CL_MULTICAST);
        plen = (len - mpe_pkg::MIN_SECTION_BYTES > (1 << mpe_pkg::PL_W) - 1) ? '1 :
               mpe_pkg::pl_t'(len - mpe_pkg::MIN_SECTION_BYTES);
        frames_good++;
      end else if (st != mpe_pkg::ST_LLC) begin
        frames_failed++;
      end
      if (status_given) st = given_status;
      pending_words.push_back('{8'h00, 1'b0, 1'b1, st, cls, plen, frames_good,
                                frames_failed});
      sec_pos     = '0;
      hdr_verdict = mpe_pkg::ST_OK;
    end else if (pos != mpe_pkg::IDX_MAX) begin
      sec_pos = pos + mpe_pkg::idx_t'(1);
    end
  endtask

  // Appends one section to the stimulus, header fields placed at their positions.
  task automatic add_section(input int len, input logic [7:0] sel, input logic [7:0] frag,
                             input logic [47:0] dest, input bit fixed_fill,
                             input logic [7:0] fill, input bit status_given,
                             input mpe_pkg::status_t given_status);
    section_word_t w;
    for (int i = 0; i < len; i++) begin
      w.section_byte = fixed_fill ? fill : 8'($urandom);
      case (i)
        3:        w.section_byte = dest[7:0];
        4:        w.section_byte = dest[15:8];
        SEL_POS:  w.section_byte = sel;
        FRAG_POS: w.section_byte = frag;
        8:        w.section_byte = dest[23:16];
        9:        w.section_byte = dest[31:24];
        10:       w.section_byte = dest[39:32];
        11:       w.section_byte = dest[47:40];
        default: ;
      endcase
      w.last_byte    = (i == len - 1);
      w.status_given = status_given;
      w.given_status = given_status;
      section_words.push_back(w);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Every accepted section word feeds the predictor.
  always @(posedge clk) begin
    if (!rst && sec.valid && sec.ready) begin
      convert_byte(sec.section_byte, sec.last_byte,
                   section_words[accepted_words].status_given,
                   section_words[accepted_words].given_status);
      accepted_words++;
    end
  end

  // Every accepted frame word is compared with the oldest expectation.
  always @(posedge clk) begin
    frame_word_t want;
    if (!rst && frm.valid && frm.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t ns: unexpected word, frame_byte %0h frame_end %0b",
                 $time, frm.frame_byte, frm.frame_end);
        failures++;
      end else begin
        want = pending_words.pop_front();
        check_field("frame_byte", want.frame_byte, frm.frame_byte);
        check_field("frame_byte_valid", want.frame_byte_valid, frm.frame_byte_valid);
        check_field("frame_end", want.frame_end, frm.frame_end);
        check_field("status", want.status, frm.status);
        check_field("frame_class", want.frame_class, frm.frame_class);
        check_field("payload_length", want.payload_length, frm.payload_length);
        check_field("good_frames", want.good_frames, frm.good_frames);
        check_field("error_frames", want.error_frames, frm.error_frames);
      end
    end
  end

  // Frame channel readiness: random stalls with calm stretches.
  initial begin
    int stall;
    bit calm;
    frm.ready = 1'b0;
    calm = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        frm.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      frm.ready <= 1'b1;
      @(posedge clk);
      while (!frm.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus build, section channel driving and end of run.
  initial begin
    int          len;
    int          rand_items;
    int          gap;
    bit          calm;
    logic [7:0]  sel;
    logic [7:0]  frag;
    sec.valid        = 1'b0;
    sec.section_byte = 8'h00;
    sec.last_byte    = 1'b0;

    foreach (directed_rows[r])
      add_section(directed_rows[r].len, directed_rows[r].sel_byte, directed_rows[r].frag_byte,
                  directed_rows[r].dest_mac, 1'b1, directed_rows[r].fill, 1'b1,
                  directed_rows[r].status);

    // Random sections, mostly well formed, some with broken headers or too short.
    rand_items = 0;
    while (rand_items < 200) begin
      sel  = mpe_pkg::SEL_VALUE;
      frag = 8'h00;
      case ($urandom_range(0, 9))
        0: sel = mpe_pkg::SEL_VALUE | mpe_pkg::LLC_BIT;
        1: begin
          sel = 8'($urandom);
          if ((sel & mpe_pkg::SEL_MASK) == mpe_pkg::SEL_VALUE) sel ^= 8'h10;
        end
        2: frag = 8'($urandom_range(1, 255));
        default: ;
      endcase
      len = ($urandom_range(0, 5) == 0) ?
            $urandom_range(1, mpe_pkg::MIN_SECTION_BYTES - 1) :
            $urandom_range(mpe_pkg::MIN_SECTION_BYTES, 48);
      add_section(len, sel, frag, random_dest(), 1'b0, 8'h00, 1'b0, mpe_pkg::ST_OK);
      rand_items += len;
    end

    // Drive every word with a random gap in front of it.
    calm = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    foreach (section_words[i]) begin
      if ($urandom_range(0, 31) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        sec.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      sec.valid        <= 1'b1;
      sec.section_byte <= section_words[i].section_byte;
      sec.last_byte    <= section_words[i].last_byte;
      @(posedge clk);
      while (!sec.ready) @(posedge clk);
      @(negedge clk);
    end
    sec.valid <= 1'b0;

    // Drain, then give stray words a chance to show up.
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/mpe_pkg.sv
rtl/mpe_in_if.sv
rtl/mpe_out_if.sv
rtl/mpe_section_to_ethernet_top.sv
verif/tb_mpe_section_to_ethernet_top.sv
